// ===== src/slope_lim_pkg.sv =====
`default_nettype none

package slope_lim_pkg;

  localparam int DATA_W            = 32;
  localparam int OMEGA_W           = 31;
  localparam int LIM_W             = 17;
  localparam int QUO_W             = 16;
  localparam int OP_W              = 2;
  localparam int DIMENSIONS_DEF    = 3;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int MAX_DIMS          = 3;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [OMEGA_W-1:0]       omega_t;
  typedef logic [LIM_W-1:0]         lim_t;
  typedef logic [OP_W-1:0]          op_t;

  localparam lim_t LIM_ONE = lim_t'(1) << QUO_W;

  localparam op_t OP_START    = 2'd0;
  localparam op_t OP_NEIGHBOR = 2'd1;
  localparam op_t OP_FACE     = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_PREP,
    ST_CHECK,
    ST_DIV,
    ST_UPD,
    ST_EMIT
  } state_e;

endpackage

`default_nettype wire

// ===== src/slope_lim_if.sv =====
`default_nettype none

interface slope_lim_in_if;
  import slope_lim_pkg::*;
  logic  valid;
  logic  ready;
  op_t   operation;
  data_t sample_value;
  data_t grad_x;
  data_t grad_y;
  data_t grad_z;
  data_t r_x;
  data_t r_y;
  data_t r_z;
  logic  last_item;

  modport source (
    output valid, operation, sample_value, grad_x, grad_y, grad_z, r_x, r_y, r_z,
           last_item,
    input  ready
  );
  modport sink (
    input  valid, operation, sample_value, grad_x, grad_y, grad_z, r_x, r_y, r_z,
           last_item,
    output ready
  );
endinterface

interface slope_lim_out_if;
  import slope_lim_pkg::*;
  logic valid;
  logic ready;
  lim_t limiter_value;

  modport source (output valid, limiter_value, input ready);
  modport sink (input valid, limiter_value, output ready);
endinterface

interface slope_lim_cfg_if;
  import slope_lim_pkg::*;
  logic   valid;
  logic   ready;
  omega_t omega_bias;

  modport source (output valid, omega_bias, input ready);
  modport sink (input valid, omega_bias, output ready);
endinterface

`default_nettype wire

// ===== src/slope_limiter_per_cell_unit.sv =====
// Barth-Jespersen style slope limiter for one flow variable of one cell.
// Input channel: a start transfer (cell value and gradient), then one
// neighbour transfer per adjacent cell, then one face transfer per face with
// the centre-to-face vector; last_item marks the final face (or the start of
// a cell without faces). Output channel: one limiter value (Q1.16, 65536 is
// 1.0) per cell, sent after the last face. Config channel: omega_bias, always
// ready, to be written while the block is idle.
// Start and neighbour transfers are handled in the idle state. A face transfer
// runs through one shared 32x32 multiplier, a sum, set-up and check steps, a
// restoring divider at one quotient bit per cycle and a limiter update; after
// the last face a send step follows. A face whose limiter saturates at 1.0
// (zero magnitude, or a difference no smaller than the magnitude) skips the
// divider. The input is not ready while a face is in progress.
// Reset clears the cell state to zero, the running limiter to 1.0 and
// omega_bias to zero; no clearing pass is needed.
// The result sits in an output register, so further items are taken while it
// waits; if the receiver stalls and the next result is due, the block holds
// in its send step until the register frees.
`default_nettype none

module slope_limiter_per_cell_unit #(
  parameter int DIMENSIONS    = slope_lim_pkg::DIMENSIONS_DEF,
  parameter int FRACTION_BITS = slope_lim_pkg::FRACTION_BITS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  slope_lim_in_if.sink           in_i,
  slope_lim_out_if.source        out_o,
  slope_lim_cfg_if.sink          cfg_i
);
  import slope_lim_pkg::*;

  localparam int PROD_W = 2 * DATA_W;
  localparam int SUM_W  = PROD_W + $clog2(DIMENSIONS);
  localparam int MAG_W  = SUM_W - FRACTION_BITS;
  localparam int IDX_W  = $clog2(DIMENSIONS);
  localparam int CNT_W  = $clog2(QUO_W);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DIMENSIONS - 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUO_W - 1);

  state_e state_q, state_d;

  logic [IDX_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  data_t center_q, center_d;
  data_t max_q, max_d;
  data_t min_q, min_d;
  data_t grad_q [DIMENSIONS];
  data_t grad_d [DIMENSIONS];
  data_t rvec_q [DIMENSIONS];
  data_t rvec_d [DIMENSIONS];
  data_t grad_in [MAX_DIMS];
  data_t rvec_in [MAX_DIMS];

  logic                     last_q, last_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [SUM_W-1:0]  acc_q, acc_d;
  logic [MAG_W-1:0]         mag_q, mag_d;
  logic [DATA_W-1:0]        num_q, num_d;
  logic [MAG_W-1:0]         rem_q, rem_d;
  logic [QUO_W-1:0]         quo_q, quo_d;
  lim_t                     face_q, face_d;
  lim_t                     lim_q, lim_d;
  omega_t                   omega_q, omega_d;
  logic                     out_valid_q, out_valid_d;
  lim_t                     out_data_q, out_data_d;

  logic in_fire, out_free, saturate;

  // Face set-up and divider step
  logic signed [SUM_W-1:0]  d2;
  logic [SUM_W-1:0]         abs_d2;
  logic signed [DATA_W:0]   diff_v;
  logic [MAG_W:0]           rem2, rem_sub;
  logic                     rem_ge;

  assign in_i.ready      = (state_q == ST_IDLE);
  assign cfg_i.ready     = 1'b1;
  assign out_o.valid     = out_valid_q;
  assign out_o.limiter_value = out_data_q;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign saturate = (mag_q == '0) || ({{(MAG_W - DATA_W){1'b0}}, num_q} >= mag_q);

  assign grad_in[0] = in_i.grad_x;
  assign grad_in[1] = in_i.grad_y;
  assign grad_in[2] = in_i.grad_z;
  assign rvec_in[0] = in_i.r_x;
  assign rvec_in[1] = in_i.r_y;
  assign rvec_in[2] = in_i.r_z;

  assign d2      = acc_q >>> FRACTION_BITS;
  assign abs_d2  = d2[SUM_W-1] ? SUM_W'(-d2) : SUM_W'(d2);
  assign diff_v  = d2[SUM_W-1] ? ({center_q[DATA_W-1], center_q} - {min_q[DATA_W-1], min_q})
                               : ({max_q[DATA_W-1], max_q} - {center_q[DATA_W-1], center_q});
  assign rem2    = {rem_q, 1'b0};
  assign rem_sub = rem2 - {1'b0, mag_q};
  assign rem_ge  = (rem2 >= {1'b0, mag_q});

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_i.operation)
            OP_START: begin
              if (in_i.last_item) state_d = ST_EMIT;
            end
            OP_FACE:  state_d = ST_MUL;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_MUL: begin
        if (idx_q == IDX_LAST) state_d = ST_SUM;
      end
      ST_SUM:   state_d = ST_PREP;
      ST_PREP:  state_d = ST_CHECK;
      ST_CHECK: state_d = saturate ? ST_UPD : ST_DIV;
      ST_DIV: begin
        if (cnt_q == CNT_LAST) state_d = ST_UPD;
      end
      ST_UPD:   state_d = last_q ? ST_EMIT : ST_IDLE;
      ST_EMIT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    center_d    = center_q;
    max_d       = max_q;
    min_d       = min_q;
    grad_d      = grad_q;
    rvec_d      = rvec_q;
    last_d      = last_q;
    prod_d      = prod_q;
    acc_d       = acc_q;
    mag_d       = mag_q;
    num_d       = num_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    face_d      = face_q;
    lim_d       = lim_q;
    omega_d     = omega_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;

    if (cfg_i.valid) omega_d = cfg_i.omega_bias;
    if (out_valid_q && out_o.ready) out_valid_d = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_i.operation)
            OP_START: begin
              center_d = in_i.sample_value;
              max_d    = in_i.sample_value;
              min_d    = in_i.sample_value;
              lim_d    = LIM_ONE;
              for (int d = 0; d < DIMENSIONS; d++) grad_d[d] = grad_in[d];
            end
            OP_NEIGHBOR: begin
              if (in_i.sample_value > max_q) max_d = in_i.sample_value;
              if (in_i.sample_value < min_q) min_d = in_i.sample_value;
            end
            OP_FACE: begin
              for (int d = 0; d < DIMENSIONS; d++) rvec_d[d] = rvec_in[d];
              last_d = in_i.last_item;
              idx_d  = '0;
            end
            default: ;
          endcase
        end
      end
      ST_MUL: begin
        prod_d = grad_q[idx_q] * rvec_q[idx_q];
        if (idx_q == '0) acc_d = '0;
        else acc_d = acc_q + {{(SUM_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};
        idx_d = idx_q + 1'b1;
      end
      ST_SUM: begin
        acc_d = acc_q + {{(SUM_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};
      end
      ST_PREP: begin
        mag_d = abs_d2[MAG_W-1:0] + {{(MAG_W - OMEGA_W){1'b0}}, omega_q};
        num_d = diff_v[DATA_W] ? '0 : diff_v[DATA_W-1:0];
      end
      ST_CHECK: begin
        face_d = LIM_ONE;
        rem_d  = {{(MAG_W - DATA_W){1'b0}}, num_q};
        quo_d  = '0;
        cnt_d  = '0;
      end
      ST_DIV: begin
        rem_d = rem_ge ? rem_sub[MAG_W-1:0] : rem2[MAG_W-1:0];
        quo_d = {quo_q[QUO_W-2:0], rem_ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) face_d = {1'b0, quo_q[QUO_W-2:0], rem_ge};
      end
      ST_UPD: begin
        if (face_q < lim_q) lim_d = face_q;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = lim_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      center_q    <= '0;
      max_q       <= '0;
      min_q       <= '0;
      grad_q      <= '{default: '0};
      lim_q       <= LIM_ONE;
      omega_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      center_q    <= center_d;
      max_q       <= max_d;
      min_q       <= min_d;
      grad_q      <= grad_d;
      lim_q       <= lim_d;
      omega_q     <= omega_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    cnt_q      <= cnt_d;
    rvec_q     <= rvec_d;
    last_q     <= last_d;
    prod_q     <= prod_d;
    acc_q      <= acc_d;
    mag_q      <= mag_d;
    num_q      <= num_d;
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    face_q     <= face_d;
    out_data_q <= out_data_d;
  end

endmodule

`default_nettype wire
